// File: src/pip_pkg.sv
// Package for the point-in-polygon test core: default sizes, item kind codes
// and the control structs passed between the top level and the edge unit.
// No dependencies.
package pip_pkg;

   localparam int MAX_VERTICES_DEF = 256;
   localparam int COORD_BITS_DEF   = 16;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // vertex stream from the RAM read port into the edge unit
   typedef struct packed {
      logic vld;
      logic first;   // vertex j = n-1, only primes the previous-vertex register
   } walk_type;

   // edge unit status back to the sequencer
   typedef struct packed {
      logic busy;
      logic hit_vld;
      logic hit;
   } edge_stat_type;

endpackage

// File: src/pip_if.sv
// Handshake interfaces for the point-in-polygon core: query/load item channel
// and result channel. Valid/ready, item moves when both are high.
// Depends on nothing.
interface pip_req_if #(
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic                         restart;
   logic signed [COORD_BITS-1:0] x_coord;
   logic signed [COORD_BITS-1:0] y_coord;

   modport source (output valid, kind, restart, x_coord, y_coord, input ready);
   modport sink   (input valid, kind, restart, x_coord, y_coord, output ready);
endinterface

interface pip_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;
   logic overflowed;

   modport source (output valid, inside_res, overflowed, input ready);
   modport sink   (input valid, inside_res, overflowed, output ready);
endinterface

// File: src/pip_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/pip_edge.sv
// Edge crossing unit: takes the stored vertices one per cycle and, for each
// edge (j, i), reports whether the horizontal ray from the point crosses it.
// Three stages: differences, products, compare. Depends on pip_pkg.
module pip_edge #(
   parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pip_pkg::walk_type            walk,
   input  logic signed [COORD_BITS-1:0] vx,
   input  logic signed [COORD_BITS-1:0] vy,
   input  logic signed [COORD_BITS-1:0] px,
   input  logic signed [COORD_BITS-1:0] py,
   output pip_pkg::edge_stat_type       stat
);
   import pip_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   logic signed [COORD_BITS-1:0] prevx_ff, prevy_ff;

   logic signed [DW-1:0] dxp_in, dyd_in, dxe_in, dyp_in;
   logic                 cross_in, neg_in;
   logic signed [DW-1:0] dxp_ff, dyd_ff, dxe_ff, dyp_ff;
   logic                 cross_ff, neg_ff, s1_vld_ff;

   logic signed [PW-1:0] p1_in, p2_in, p1_ff, p2_ff;
   logic                 s2_cross_ff, s2_neg_ff, s2_vld_ff;

   logic                 hit_in, hit_ff, hit_vld_ff;

   // i = current vertex, j = previous one
   always_comb begin
      dxp_in   = $signed({px[COORD_BITS-1], px}) - $signed({vx[COORD_BITS-1], vx});
      dyd_in   = $signed({prevy_ff[COORD_BITS-1], prevy_ff})
               - $signed({vy[COORD_BITS-1], vy});
      dxe_in   = $signed({prevx_ff[COORD_BITS-1], prevx_ff})
               - $signed({vx[COORD_BITS-1], vx});
      dyp_in   = $signed({py[COORD_BITS-1], py}) - $signed({vy[COORD_BITS-1], vy});
      cross_in = (vy > py) != (prevy_ff > py);
      neg_in   = prevy_ff < vy;
   end

   assign p1_in  = dxp_ff * dyd_ff;
   assign p2_in  = dxe_ff * dyp_ff;
   assign hit_in = s2_cross_ff && (s2_neg_ff ? (p2_ff < p1_ff) : (p1_ff < p2_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         hit_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= walk.vld && !walk.first;
         s2_vld_ff  <= s1_vld_ff;
         hit_vld_ff <= s2_vld_ff;
      end
      if (walk.vld) begin
         prevx_ff <= vx;
         prevy_ff <= vy;
      end
      dxp_ff      <= dxp_in;
      dyd_ff      <= dyd_in;
      dxe_ff      <= dxe_in;
      dyp_ff      <= dyp_in;
      cross_ff    <= cross_in;
      neg_ff      <= neg_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      s2_cross_ff <= cross_ff;
      s2_neg_ff   <= neg_ff;
      hit_ff      <= hit_in;
   end

   assign stat.busy    = s1_vld_ff || s2_vld_ff || hit_vld_ff;
   assign stat.hit_vld = hit_vld_ff;
   assign stat.hit     = hit_ff;

endmodule

// File: src/point_in_polygon_test_core.sv
// Point-in-polygon test core: vertex store, bounding box and query sequencer.
// Depends on pip_pkg, pip_if (pip_req_if, pip_rsp_if), pip_ram and pip_edge.
//
// A load item (kind 0) appends one vertex; restart starts a new polygon.
// Vertices past MAX_VERTICES are dropped and reported through overflowed on
// every later query until the next restart. A query item (kind 1) returns one
// result by the even-odd rule. With no vertices, or with the point outside the
// vertex bounding box, the sequencer goes straight to the result state without
// reading the RAM. Otherwise the vertex RAM is read once per stored vertex plus
// once for the closing edge, the single RAM read port walking one edge per
// cycle, and the result is given once the edge pipeline has drained. New items
// are taken whenever the sequencer is idle, also while a result waits in the
// output register.
module point_in_polygon_test_core #(
   parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
   parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   pip_req_if.sink   req_if,
   pip_rsp_if.source rsp_if
);
   import pip_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN, S_RESP} state_type;

   state_type                    state_ff, state_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic signed [COORD_BITS-1:0] minx_ff, minx_in, maxx_ff, maxx_in;
   logic signed [COORD_BITS-1:0] miny_ff, miny_in, maxy_ff, maxy_in;
   logic                         drop_ff, drop_in;
   logic signed [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic                         rd_vld_ff, rd_vld_in, rd_first_ff, rd_first_in;
   logic                         inside_ff, inside_in;
   logic                         rsp_vld_ff, rsp_vld_in;
   logic                         rsp_inside_ff, rsp_inside_in, rsp_ovf_ff, rsp_ovf_in;

   logic                         acc, is_load, is_query, full, in_box;
   logic [CW-1:0]                eff_cnt, last_addr;
   logic                         wr_en, rd_en;
   logic [AW-1:0]                wr_addr, rd_addr;
   logic [2*COORD_BITS-1:0]      wr_data, rd_data;
   walk_type                     walk;
   edge_stat_type                estat;

   assign req_if.ready = (state_ff == S_IDLE);
   assign acc       = req_if.valid && req_if.ready;
   assign is_load   = acc && (req_if.kind == KIND_LOAD);
   assign is_query  = acc && (req_if.kind == KIND_QUERY);
   assign eff_cnt   = req_if.restart ? '0 : cnt_ff;
   assign full      = (eff_cnt == CW'(MAX_VERTICES));
   assign last_addr = cnt_ff - CW'(1);
   assign in_box    = (req_if.x_coord >= minx_ff) && (req_if.x_coord <= maxx_ff)
                   && (req_if.y_coord >= miny_ff) && (req_if.y_coord <= maxy_ff);

   assign wr_en   = is_load && !full;
   assign wr_addr = eff_cnt[AW-1:0];
   assign wr_data = {req_if.y_coord, req_if.x_coord};
   assign rd_en   = (is_query && (cnt_ff != '0) && in_box) || (state_ff == S_WALK);
   assign rd_addr = (state_ff == S_WALK) ? idx_ff[AW-1:0] : last_addr[AW-1:0];

   assign walk.vld   = rd_vld_ff;
   assign walk.first = rd_first_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      minx_in       = minx_ff;
      maxx_in       = maxx_ff;
      miny_in       = miny_ff;
      maxy_in       = maxy_ff;
      drop_in       = drop_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      idx_in        = idx_ff;
      rd_vld_in     = rd_en;
      rd_first_in   = (state_ff == S_IDLE);
      inside_in     = inside_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_if.ready;
      rsp_inside_in = rsp_inside_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      if (estat.hit_vld && estat.hit) begin
         inside_in = !inside_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (is_load) begin
               if (req_if.restart) begin
                  drop_in = 1'b0;
               end
               if (full) begin
                  drop_in = 1'b1;
               end else begin
                  cnt_in = eff_cnt + CW'(1);
                  if (eff_cnt == '0) begin
                     minx_in = req_if.x_coord;
                     maxx_in = req_if.x_coord;
                     miny_in = req_if.y_coord;
                     maxy_in = req_if.y_coord;
                  end else begin
                     if (req_if.x_coord < minx_ff) minx_in = req_if.x_coord;
                     if (req_if.x_coord > maxx_ff) maxx_in = req_if.x_coord;
                     if (req_if.y_coord < miny_ff) miny_in = req_if.y_coord;
                     if (req_if.y_coord > maxy_ff) maxy_in = req_if.y_coord;
                  end
               end
            end else if (is_query) begin
               px_in     = req_if.x_coord;
               py_in     = req_if.y_coord;
               inside_in = 1'b0;
               idx_in    = '0;
               state_in  = rd_en ? S_WALK : S_RESP;
            end
         end
         S_WALK: begin
            if (idx_ff == last_addr) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         S_DRAIN: begin
            if (!rd_vld_ff && !estat.busy) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_vld_ff || rsp_if.ready) begin
               rsp_vld_in    = 1'b1;
               rsp_inside_in = inside_ff;
               rsp_ovf_in    = drop_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_ff     <= '0;
         minx_ff    <= '0;
         maxx_ff    <= '0;
         miny_ff    <= '0;
         maxy_ff    <= '0;
         drop_ff    <= 1'b0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         minx_ff    <= minx_in;
         maxx_ff    <= maxx_in;
         miny_ff    <= miny_in;
         maxy_ff    <= maxy_in;
         drop_ff    <= drop_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      px_ff         <= px_in;
      py_ff         <= py_in;
      idx_ff        <= idx_in;
      rd_first_ff   <= rd_first_in;
      inside_ff     <= inside_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_if.valid      = rsp_vld_ff;
   assign rsp_if.inside_res = rsp_inside_ff;
   assign rsp_if.overflowed = rsp_ovf_ff;

   pip_ram #(
      .WIDTH (2 * COORD_BITS),
      .DEPTH (MAX_VERTICES)
   ) u_vert_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pip_edge #(
      .COORD_BITS (COORD_BITS)
   ) u_edge (
      .clock (clock),
      .reset (reset),
      .walk  (walk),
      .vx    (rd_data[COORD_BITS-1:0]),
      .vy    (rd_data[2*COORD_BITS-1:COORD_BITS]),
      .px    (px_ff),
      .py    (py_ff),
      .stat  (estat)
   );

   // no edge work may be in flight while new items are taken
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> (!rd_vld_ff && !estat.busy))
      else $error("edge pipeline busy while idle");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_VERTICES))
      else $error("vertex count beyond capacity");

   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (cnt_ff != '0))
      else $error("edge walk over an empty polygon");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> ($past(state_ff) == S_RESP))
      else $error("result issued outside the result state");

endmodule

// File: tb/sv/tb_point_in_polygon_test_core.sv
`timescale 1ns / 100ps
// Testbench for point_in_polygon_test_core: loads polygons, sends point queries
// and checks each result against a predictor of the even-odd crossing test.
// Depends on pip_pkg, pip_if and the core itself.
module tb_point_in_polygon_test_core;
   import pip_pkg::*;

   localparam int NV           = MAX_VERTICES_DEF;
   localparam int IW           = $clog2(NV);
   localparam int CW           = COORD_BITS_DEF;
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 250;

   typedef struct {
      logic in_poly;
      logic dropped;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pip_req_if #(.COORD_BITS(CW)) req_bus ();
   pip_rsp_if rsp_bus ();

   point_in_polygon_test_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always #4 clock = ~clock;

   // predictor state
   logic signed [CW-1:0] poly_x [NV];
   logic signed [CW-1:0] poly_y [NV];
   int unsigned          poly_count = 0;
   logic signed [CW-1:0] lo_x = '0, hi_x = '0, lo_y = '0, hi_y = '0;
   logic                 store_overflow = 1'b0;

   verdict_type verdict_q [$];
   int       mismatch_count = 0;
   int       items_sent = 0;
   int       idle_cycles = 0;
   int       rsp_stall = 0;
   bit       calm = 1'b0;

   function automatic logic point_inside(logic signed [CW-1:0] px_in,
                                         logic signed [CW-1:0] py_in);
      longint px, py, xi, yi, xj, yj, den, lhs, rhs;
      int unsigned j;
      logic in_poly;
      px = longint'(px_in);
      py = longint'(py_in);
      in_poly = 1'b0;
      if (poly_count == 0) return 1'b0;
      if (px_in < lo_x || px_in > hi_x || py_in < lo_y || py_in > hi_y) return 1'b0;
      j = poly_count - 1;
      for (int unsigned i = 0; i < poly_count; i++) begin
         xi = longint'(poly_x[IW'(i)]);
         yi = longint'(poly_y[IW'(i)]);
         xj = longint'(poly_x[IW'(j)]);
         yj = longint'(poly_y[IW'(j)]);
         if ((yi > py) != (yj > py)) begin
            den = yj - yi;
            lhs = (px - xi) * den;
            rhs = (xj - xi) * (py - yi);
            if (den > 0 ? (lhs < rhs) : (rhs < lhs))
               in_poly = ~in_poly;
         end
         j = i;
      end
      return in_poly;
   endfunction

   task automatic track_item(logic kind, logic restart,
                             logic signed [CW-1:0] x, logic signed [CW-1:0] y);
      verdict_type v;
      if (kind == KIND_QUERY) begin
         v.in_poly = point_inside(x, y);
         v.dropped = store_overflow;
         verdict_q.push_back(v);
         return;
      end
      if (restart) begin
         poly_count = 0;
         store_overflow = 1'b0;
      end
      if (poly_count >= NV) begin
         store_overflow = 1'b1;
         return;
      end
      poly_x[IW'(poly_count)] = x;
      poly_y[IW'(poly_count)] = y;
      if (poly_count == 0) begin
         lo_x = x; hi_x = x; lo_y = y; hi_y = y;
      end else begin
         if (x < lo_x) lo_x = x;
         if (x > hi_x) hi_x = x;
         if (y < lo_y) lo_y = y;
         if (y > hi_y) hi_y = y;
      end
      poly_count++;
   endtask

   function automatic logic signed [CW-1:0] clip_coord(int v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[CW-1:0];
   endfunction

   function automatic int rand_between(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   // starts and ends at a falling edge; valid stays high into a back-to-back item
   task automatic send_item(logic kind, logic restart, int x, int y);
      int gap;
      logic signed [CW-1:0] xs, ys;
      gap = calm ? 0 : $urandom_range(3);
      xs = clip_coord(x);
      ys = clip_coord(y);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.kind    = kind;
      req_bus.restart = restart;
      req_bus.x_coord = xs;
      req_bus.y_coord = ys;
      req_bus.valid   = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      track_item(kind, restart, xs, ys);
      items_sent++;
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_bus.ready = 1'b0;
         rsp_stall--;
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      verdict_type v;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_stall = calm ? 0 : $urandom_range(3);
         if (verdict_q.size() == 0) begin
            $display("%0t: result with nothing expected: inside_res %b overflowed %b",
                     $time, rsp_bus.inside_res, rsp_bus.overflowed);
            mismatch_count++;
         end else begin
            v = verdict_q.pop_front();
            if (rsp_bus.inside_res !== v.in_poly) begin
               $display("%0t: inside_res expected %b actual %b",
                        $time, v.in_poly, rsp_bus.inside_res);
               mismatch_count++;
            end
            if (rsp_bus.overflowed !== v.dropped) begin
               $display("%0t: overflowed expected %b actual %b",
                        $time, v.dropped, rsp_bus.overflowed);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_point_in_polygon_test_core: done, errors");
         $finish;
      end
   end

   // empty polygon, restart bit on queries
   task automatic test_empty_polygon();
      send_item(KIND_QUERY, 1'b0, 0, 0);
      send_item(KIND_QUERY, 1'b1, -32768, 32767);
      send_item(KIND_QUERY, 1'b0, 32767, -32768);
   endtask

   // square: interior, box edges, a corner, horizontal edges, outside box
   task automatic test_square();
      send_item(KIND_LOAD, 1'b1, -100, -100);
      send_item(KIND_LOAD, 1'b0, 100, -100);
      send_item(KIND_LOAD, 1'b0, 100, 100);
      send_item(KIND_LOAD, 1'b0, -100, 100);
      send_item(KIND_QUERY, 1'b0, 0, 0);
      send_item(KIND_QUERY, 1'b1, 0, 0);
      send_item(KIND_QUERY, 1'b0, 101, 0);
      send_item(KIND_QUERY, 1'b0, 100, 0);
      send_item(KIND_QUERY, 1'b0, -100, 0);
      send_item(KIND_QUERY, 1'b0, 0, 100);
      send_item(KIND_QUERY, 1'b0, 0, -100);
      send_item(KIND_QUERY, 1'b0, -100, -100);
   endtask

   // full-range triangle, then degenerate one- and two-vertex polygons
   task automatic test_extremes();
      send_item(KIND_LOAD, 1'b1, -32768, -32768);
      send_item(KIND_LOAD, 1'b0, 32767, -32768);
      send_item(KIND_LOAD, 1'b0, 0, 32767);
      send_item(KIND_QUERY, 1'b0, 0, 0);
      send_item(KIND_QUERY, 1'b0, 32767, 32767);
      send_item(KIND_QUERY, 1'b0, -32768, -32768);
      send_item(KIND_QUERY, 1'b0, -1, -1);
      send_item(KIND_LOAD, 1'b1, 7, -7);
      send_item(KIND_QUERY, 1'b0, 7, -7);
      send_item(KIND_LOAD, 1'b0, -32768, 32767);
      send_item(KIND_QUERY, 1'b0, -5, 5);
   endtask

   // fill the store, overflow it, then clear the flag with a restart
   task automatic test_store_full();
      for (int k = 0; k < NV; k++)
         send_item(KIND_LOAD, k == 0, rand_between(-3000, 3000), rand_between(-3000, 3000));
      send_item(KIND_QUERY, 1'b0, rand_between(-3000, 3000), rand_between(-3000, 3000));
      for (int k = 0; k < 3; k++)
         send_item(KIND_LOAD, 1'b0, rand_between(-32768, 32767), rand_between(-32768, 32767));
      for (int k = 0; k < 4; k++)
         send_item(KIND_QUERY, 1'b0, rand_between(-3000, 3000), rand_between(-3000, 3000));
      send_item(KIND_QUERY, 1'b0, 20000, 20000);
      send_item(KIND_LOAD, 1'b1, 0, 0);
      send_item(KIND_LOAD, 1'b0, 50, 0);
      send_item(KIND_LOAD, 1'b0, 0, 50);
      send_item(KIND_QUERY, 1'b0, 10, 10);
   endtask

   task automatic test_random_polygons();
      int stop_at, n, nq, span, mid_x, mid_y, pick, idx;
      bit extend;
      logic rs;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         calm = ($urandom_range(4) == 0);
         pick = $urandom_range(9);
         n = (pick == 0) ? $urandom_range(2, 1) :
             (pick == 1) ? $urandom_range(40, 16) : $urandom_range(12, 3);
         case ($urandom_range(3))
            0:       span = $urandom_range(8, 1);
            3:       span = 32767;
            default: span = $urandom_range(2000, 20);
         endcase
         mid_x = rand_between(-32768, 32767);
         mid_y = rand_between(-32768, 32767);
         extend = ($urandom_range(7) == 0);
         for (int v = 0; v < n; v++) begin
            rs = (v == 0 && !extend) || ($urandom_range(29) == 0);
            send_item(KIND_LOAD, rs, mid_x + rand_between(-span, span),
                      mid_y + rand_between(-span, span));
         end
         nq = $urandom_range(6, 2);
         for (int q = 0; q < nq; q++) begin
            rs = 1'($urandom_range(1));
            pick = $urandom_range(9);
            if (pick <= 6) begin
               send_item(KIND_QUERY, rs, rand_between(lo_x, hi_x), rand_between(lo_y, hi_y));
            end else if (pick == 7) begin
               idx = $urandom_range(poly_count - 1);
               send_item(KIND_QUERY, rs, poly_x[IW'(idx)], poly_y[IW'(idx)]);
            end else begin
               send_item(KIND_QUERY, rs, rand_between(-32768, 32767),
                         rand_between(-32768, 32767));
            end
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.kind    = KIND_LOAD;
      req_bus.restart = 1'b0;
      req_bus.x_coord = '0;
      req_bus.y_coord = '0;
      rsp_bus.ready   = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_polygon();
      test_square();
      test_extremes();
      test_store_full();
      test_random_polygons();

      req_bus.valid = 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && verdict_q.size() == 0)
         $display("tb_point_in_polygon_test_core: done, clean");
      else
         $display("tb_point_in_polygon_test_core: done, errors");
      $finish;
   end

endmodule

// File: point_in_polygon_test_core.f
src/pip_pkg.sv
src/pip_if.sv
src/pip_ram.sv
src/pip_edge.sv
src/point_in_polygon_test_core.sv
tb/sv/tb_point_in_polygon_test_core.sv
